FILE: sv/prarb_pkg.sv
package prarb_pkg;

  localparam int unsigned ClientsDefault = 16;
  localparam int unsigned QueueDepth     = 2;

  localparam logic [1:0] KIND_REG = 2'd0;
  localparam logic [1:0] KIND_REQ = 2'd1;
  localparam logic [1:0] KIND_REL = 2'd2;
  localparam logic [1:0] KIND_BAD = 2'd3;

  localparam logic EV_GRANT = 1'b0;
  localparam logic EV_DENY  = 1'b1;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] client;
    logic [7:0] prio;
  } req_t;

  typedef struct packed {
    logic       event_res;
    logic [3:0] target;
    logic       last;
  } evt_t;

endpackage

FILE: sv/prarb_front.sv
module prarb_front #(
  parameter int unsigned CLIENTS = prarb_pkg::ClientsDefault
) (
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  prarb_pkg::req_t in_word_i,
  input  logic            q_full_i,
  output logic            q_push_o,
  output prarb_pkg::req_t q_word_o
);
  import prarb_pkg::*;

  logic legal;

  // drop unknown kinds and clients beyond the configured count
  assign legal      = (in_word_i.kind != KIND_BAD) && (7'(in_word_i.client) < 7'(CLIENTS));
  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i && legal;
  assign q_word_o   = in_word_i;

endmodule

FILE: sv/prarb_fifo.sv
module prarb_fifo #(
  parameter int unsigned DEPTH = prarb_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  prarb_pkg::req_t push_word_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output prarb_pkg::req_t pop_word_o
);
  import prarb_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  req_t          mem_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o     = (cnt_q == CW'(DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_word_o = mem_q[rd_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LAST_PTR) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == LAST_PTR) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_word_i;
    end
  end

endmodule

FILE: sv/prarb_back.sv
module prarb_back #(
  parameter int unsigned CLIENTS = prarb_pkg::ClientsDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  prarb_pkg::req_t q_word_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output prarb_pkg::evt_t out_word_o
);
  import prarb_pkg::*;

  localparam int unsigned IW = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(CLIENTS - 1);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCAN   = 6'b000010,
    ST_DECIDE = 6'b000100,
    ST_DENY   = 6'b001000,
    ST_OLD    = 6'b010000,
    ST_NEW    = 6'b100000
  } state_e;

  state_e         st_q, st_d;
  logic [IW-1:0]  idx_q, idx_d;
  logic [IW-1:0]  best_q, best_d;
  logic [7:0]     best_prio_q, best_prio_d;
  logic           found_q, found_d;
  logic [IW-1:0]  owner_q, owner_d;
  logic           owner_valid_q, owner_valid_d;
  logic [IW-1:0]  old_q, old_d;
  logic [CLIENTS-1:0] active_q, active_d;
  logic [CLIENTS-1:0] reg_q, reg_d;
  logic [7:0]     prio_q [CLIENTS];
  logic [7:0]     prio_d [CLIENTS];
  logic           out_valid_q, out_valid_d;
  evt_t           out_q, out_d;
  logic           slot_free;
  logic [IW-1:0]  cidx;
  logic [CLIENTS-1:0] above;
  logic           none_after;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign cidx        = IW'(q_word_i.client);
  assign above       = reg_q >> idx_q;
  assign none_after  = ((above >> 1) == '0);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  always_comb begin
    st_d          = st_q;
    idx_d         = idx_q;
    best_d        = best_q;
    best_prio_d   = best_prio_q;
    found_d       = found_q;
    owner_d       = owner_q;
    owner_valid_d = owner_valid_q;
    old_d         = old_q;
    active_d      = active_q;
    reg_d         = reg_q;
    prio_d        = prio_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_d         = out_q;
    q_pop_o       = 1'b0;
    case (st_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          idx_d   = '0;
          found_d = 1'b0;
          case (q_word_i.kind)
            KIND_REG: begin
              reg_d[cidx] = 1'b1;
            end
            KIND_REQ: begin
              active_d[cidx] = 1'b1;
              prio_d[cidx]   = q_word_i.prio;
              st_d           = ST_SCAN;
            end
            KIND_REL: begin
              active_d[cidx] = 1'b0;
              prio_d[cidx]   = 8'd0;
              st_d           = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (active_q[idx_q] && (!found_q || (prio_q[idx_q] > best_prio_q))) begin
          best_d      = idx_q;
          best_prio_d = prio_q[idx_q];
          found_d     = 1'b1;
        end
        if (idx_q == LAST_IDX) begin
          st_d = ST_DECIDE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_DECIDE: begin
        if (!found_q) begin
          idx_d = '0;
          st_d  = ST_DENY;
        end else if (owner_valid_q && (owner_q == best_q)) begin
          st_d = ST_IDLE;
        end else begin
          old_d         = owner_q;
          owner_d       = best_q;
          owner_valid_d = 1'b1;
          if (owner_valid_q && reg_q[owner_q]) begin
            st_d = ST_OLD;
          end else if (reg_q[best_q]) begin
            st_d = ST_NEW;
          end else begin
            st_d = ST_IDLE;
          end
        end
      end
      ST_DENY: begin
        if (!reg_q[idx_q] || slot_free) begin
          if (reg_q[idx_q]) begin
            out_valid_d     = 1'b1;
            out_d.event_res = EV_DENY;
            out_d.target    = 4'(idx_q);
            out_d.last      = none_after;
          end
          if (idx_q == LAST_IDX) begin
            st_d = ST_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      ST_OLD: begin
        if (slot_free) begin
          out_valid_d     = 1'b1;
          out_d.event_res = EV_DENY;
          out_d.target    = 4'(old_q);
          out_d.last      = !reg_q[best_q];
          st_d            = reg_q[best_q] ? ST_NEW : ST_IDLE;
        end
      end
      ST_NEW: begin
        if (slot_free) begin
          out_valid_d     = 1'b1;
          out_d.event_res = EV_GRANT;
          out_d.target    = 4'(best_q);
          out_d.last      = 1'b1;
          st_d            = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q          <= ST_IDLE;
      idx_q         <= '0;
      found_q       <= 1'b0;
      owner_q       <= '0;
      owner_valid_q <= 1'b0;
      active_q      <= '0;
      reg_q         <= '0;
      out_valid_q   <= 1'b0;
      for (int i = 0; i < CLIENTS; i++) begin
        prio_q[i] <= 8'd0;
      end
    end else begin
      st_q          <= st_d;
      idx_q         <= idx_d;
      found_q       <= found_d;
      owner_q       <= owner_d;
      owner_valid_q <= owner_valid_d;
      active_q      <= active_d;
      reg_q         <= reg_d;
      out_valid_q   <= out_valid_d;
      prio_q        <= prio_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q      <= best_d;
    best_prio_q <= best_prio_d;
    old_q       <= old_d;
    out_q       <= out_d;
  end

endmodule

FILE: sv/priority_resource_arbiter.sv
// channel | handshake             | word
// --------+-----------------------+----------------------------------
// input   | in_valid_i/in_ready_o | in_word_i  : kind, client, prio
// output  | out_valid_o/out_ready_i | out_word_o : event_res, target, last
//
// Register words are handled in the back end without a scan; unknown kinds and
// out-of-range clients are dropped at intake and never reach the queue.
// Request and release: a pop, a scan of all CLIENTS slots, a decide step,
// then the grant/deny words; a deny-all pass walks all CLIENTS slots.
// A two-entry queue splits intake from the scanner so input keeps flowing.
// Reset is asynchronous and clears all request, registration and owner state.
// Output stalls hold the event sequence; the queue fills and drops in_ready_o.
module priority_resource_arbiter #(
  parameter int unsigned CLIENTS = prarb_pkg::ClientsDefault,
  parameter int unsigned QDEPTH  = prarb_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  prarb_pkg::req_t in_word_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output prarb_pkg::evt_t out_word_o
);
  import prarb_pkg::*;

  logic q_full, q_push, q_empty, q_pop;
  req_t q_in, q_out;

  prarb_front #(.CLIENTS(CLIENTS)) u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_word_o   (q_in)
  );

  prarb_fifo #(.DEPTH(QDEPTH)) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_word_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_word_o  (q_out)
  );

  prarb_back #(.CLIENTS(CLIENTS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_word_i    (q_out),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

FILE: tb/tb_priority_resource_arbiter.sv
module tb_priority_resource_arbiter;
  import prarb_pkg::*;

  localparam int unsigned Settle    = 2 * ClientsDefault + 40;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned RandItems = 500;
  localparam evt_t NoEv = '0;

  typedef struct packed {
    logic             typed;
    logic [2:0]       cnt;
    evt_t [0:3]       evs;
  } tag_t;

  typedef struct packed {
    req_t w;
    tag_t t;
  } row_t;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  req_t in_word_i   = '0;
  logic out_ready_i = 1'b0;
  logic in_ready_o;
  logic out_valid_o;
  evt_t out_word_o;

  tag_t word_tag  = '0;
  bit   full_rate = 1'b0;
  bit   choke_req = 1'b0;
  int   errs      = 0;

  evt_t event_q [$];
  evt_t burst [$];
  row_t plan [$];

  logic       owner_ok = 1'b0;
  logic [4:0] owner_q  = '0;
  logic       req_on  [ClientsDefault] = '{default: 1'b0};
  logic [7:0] req_pri [ClientsDefault] = '{default: 8'd0};
  logic       reg_on  [ClientsDefault] = '{default: 1'b0};
  logic [15:0] shadow_on = '0;

  priority_resource_arbiter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #30_000_000;
    $display("priority_resource_arbiter: mismatch");
    $finish;
  end

  function automatic evt_t ev(input logic r, input logic [3:0] t, input logic l);
    ev = {r, t, l};
  endfunction

  function automatic row_t mk(input logic [1:0] k, input logic [3:0] c, input logic [7:0] p,
                              input logic typed, input logic [2:0] n,
                              input evt_t e0, input evt_t e1, input evt_t e2);
    mk = {k, c, p, typed, n, e0, e1, e2, NoEv};
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (full_rate || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void predict_events(input req_t w);
    logic       found;
    logic [3:0] best;
    logic       arb;
    found = 1'b0;
    best  = '0;
    arb   = 1'b0;
    burst.delete();
    if (int'(w.client) >= ClientsDefault) return;
    case (w.kind)
      KIND_REG: reg_on[w.client] = 1'b1;
      KIND_REQ: begin
        req_on[w.client]  = 1'b1;
        req_pri[w.client] = w.prio;
        arb = 1'b1;
      end
      KIND_REL: begin
        req_on[w.client]  = 1'b0;
        req_pri[w.client] = 8'd0;
        arb = 1'b1;
      end
      default: ;
    endcase
    if (!arb) return;
    for (int i = 0; i < ClientsDefault; i++) begin
      if (req_on[i] && (!found || req_pri[i] > req_pri[best])) begin
        best  = 4'(i);
        found = 1'b1;
      end
    end
    if (!found) begin
      for (int i = 0; i < ClientsDefault; i++) begin
        if (reg_on[i]) burst.push_back(ev(EV_DENY, 4'(i), 1'b0));
      end
    end else if (!owner_ok || owner_q != {1'b0, best}) begin
      if (owner_ok && reg_on[owner_q[3:0]]) burst.push_back(ev(EV_DENY, owner_q[3:0], 1'b0));
      owner_q  = {1'b0, best};
      owner_ok = 1'b1;
      if (reg_on[best]) burst.push_back(ev(EV_GRANT, best, 1'b0));
    end
    if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
  endfunction

  function automatic req_t pick_word(input int unsigned req_pct);
    int unsigned r;
    int unsigned s;
    req_t w;
    r = $urandom_range(0, 99);
    w.client = 4'($urandom_range(0, 15));
    w.prio   = 8'($urandom_range(0, 255));
    if (r < 6) begin
      w.kind = KIND_REG;
    end else if (r < 9) begin
      w.kind = KIND_BAD;
    end else if (r < 9 + req_pct) begin
      w.kind = KIND_REQ;
      s = $urandom_range(0, 9);
      if (s < 2) w.prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      else if (s < 5) w.prio = 8'($urandom_range(0, 3));
      shadow_on[w.client] = 1'b1;
    end else begin
      w.kind = KIND_REL;
      if (shadow_on != '0 && $urandom_range(0, 4) != 0) begin
        while (!shadow_on[w.client]) w.client = 4'($urandom_range(0, 15));
      end
      shadow_on[w.client] = 1'b0;
    end
    return w;
  endfunction

  task automatic offer_word(input req_t w, input tag_t t);
    int unsigned gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    word_tag   <= t;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (event_q.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : track_input
    if (rst_ni && in_valid_i && in_ready_o) begin
      predict_events(in_word_i);
      if (word_tag.typed) begin
        for (int k = 0; k < int'(word_tag.cnt); k++) event_q.push_back(word_tag.evs[k]);
      end else begin
        foreach (burst[k]) event_q.push_back(burst[k]);
      end
    end
  end

  always @(posedge clk_i) begin : check_output
    evt_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (event_q.size() == 0) begin
        $error("unexpected word: event_res %0d target %0d last %0d",
               out_word_o.event_res, out_word_o.target, out_word_o.last);
        errs++;
      end else begin
        want = event_q.pop_front();
        if (want.event_res !== out_word_o.event_res) begin
          $error("event_res: expected %0d, got %0d", want.event_res, out_word_o.event_res);
          errs++;
        end
        if (want.target !== out_word_o.target) begin
          $error("target: expected %0d, got %0d", want.target, out_word_o.target);
          errs++;
        end
        if (want.last !== out_word_o.last) begin
          $error("last: expected %0d, got %0d", want.last, out_word_o.last);
          errs++;
        end
      end
    end
  end

  initial begin : drive_ready
    int unsigned n;
    @(posedge rst_ni);
    forever begin
      if (choke_req) begin
        n = HoldCycles;
        choke_req = 1'b0;
      end else begin
        n = idle_len();
      end
      if (n > 0) begin
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  initial begin : drive_words
    plan.push_back(mk(KIND_REQ, 4'd0, 8'd10, 1'b1, 3'd0, NoEv, NoEv, NoEv));
    plan.push_back(mk(KIND_REL, 4'd0, 8'd0, 1'b1, 3'd0, NoEv, NoEv, NoEv));
    plan.push_back(mk(KIND_REG, 4'd0, 8'd0, 1'b1, 3'd0, NoEv, NoEv, NoEv));
    plan.push_back(mk(KIND_REG, 4'd15, 8'd255, 1'b1, 3'd0, NoEv, NoEv, NoEv));
    plan.push_back(mk(KIND_REG, 4'd7, 8'd0, 1'b1, 3'd0, NoEv, NoEv, NoEv));
    plan.push_back(mk(KIND_REG, 4'd0, 8'd0, 1'b1, 3'd0, NoEv, NoEv, NoEv));
    plan.push_back(mk(KIND_REQ, 4'd15, 8'd255, 1'b1, 3'd2,
                      ev(EV_DENY, 4'd0, 1'b0), ev(EV_GRANT, 4'd15, 1'b1), NoEv));
    plan.push_back(mk(KIND_REQ, 4'd7, 8'd255, 1'b1, 3'd2,
                      ev(EV_DENY, 4'd15, 1'b0), ev(EV_GRANT, 4'd7, 1'b1), NoEv));
    plan.push_back(mk(KIND_REQ, 4'd7, 8'd0, 1'b1, 3'd2,
                      ev(EV_DENY, 4'd7, 1'b0), ev(EV_GRANT, 4'd15, 1'b1), NoEv));
    plan.push_back(mk(KIND_REQ, 4'd15, 8'd200, 1'b1, 3'd0, NoEv, NoEv, NoEv));
    plan.push_back(mk(KIND_REQ, 4'd3, 8'd201, 1'b1, 3'd1,
                      ev(EV_DENY, 4'd15, 1'b1), NoEv, NoEv));
    plan.push_back(mk(KIND_REL, 4'd3, 8'd0, 1'b1, 3'd1,
                      ev(EV_GRANT, 4'd15, 1'b1), NoEv, NoEv));
    plan.push_back(mk(KIND_REL, 4'd15, 8'd0, 1'b1, 3'd2,
                      ev(EV_DENY, 4'd15, 1'b0), ev(EV_GRANT, 4'd7, 1'b1), NoEv));
    plan.push_back(mk(KIND_REL, 4'd7, 8'd0, 1'b1, 3'd3, ev(EV_DENY, 4'd0, 1'b0),
                      ev(EV_DENY, 4'd7, 1'b0), ev(EV_DENY, 4'd15, 1'b1)));
    plan.push_back(mk(KIND_BAD, 4'd5, 8'd99, 1'b1, 3'd0, NoEv, NoEv, NoEv));
    plan.push_back(mk(KIND_REQ, 4'd7, 8'd0, 1'b1, 3'd0, NoEv, NoEv, NoEv));
    plan.push_back(mk(KIND_REG, 4'd1, 8'd0, 1'b0, 3'd0, NoEv, NoEv, NoEv));
    plan.push_back(mk(KIND_REG, 4'd14, 8'd0, 1'b0, 3'd0, NoEv, NoEv, NoEv));
    plan.push_back(mk(KIND_REL, 4'd7, 8'd0, 1'b0, 3'd0, NoEv, NoEv, NoEv));
    plan.push_back(mk(KIND_REL, 4'd2, 8'd0, 1'b0, 3'd0, NoEv, NoEv, NoEv));
    plan.push_back(mk(KIND_REQ, 4'd8, 8'd128, 1'b0, 3'd0, NoEv, NoEv, NoEv));
    plan.push_back(mk(KIND_BAD, 4'd15, 8'd255, 1'b0, 3'd0, NoEv, NoEv, NoEv));
    shadow_on = 16'h0100;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) offer_word(plan[i].w, plan[i].t);
    drain();

    for (int i = 0; i < RandItems; i++) begin
      full_rate = (i >= 150 && i < 200) || (i >= 400 && i < 450);
      if (i == 150) choke_req = 1'b1;
      if (i == 300) drain();
      offer_word(pick_word((i >= 200 && i < 300) ? 35 : 55), '0);
    end
    full_rate = 1'b0;
    drain();

    if (errs == 0) begin
      $display("priority_resource_arbiter: match");
    end else begin
      $display("priority_resource_arbiter: mismatch");
    end
    $finish;
  end

endmodule
